### src/srrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot and round-robin scheduler package
// Request and result types and event codes shared by the scheduler.
// ----------------------------------------------------------------------------
package srrs_pkg;

   localparam logic [5:0] WINDOW_SECONDS = 6'd60;

   typedef enum logic [2:0] {
      EV_ADMIT    = 3'd0,
      EV_PAST     = 3'd1,
      EV_CONFLICT = 3'd2,
      EV_FULL     = 3'd3,
      EV_STOP     = 3'd4,
      EV_RESUME   = 3'd5
   } event_type;

   localparam logic OP_ADMIT = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic       timed_policy;
      logic [7:0] task_id;
      logic [5:0] start_second;
      logic [5:0] run_seconds;
      logic [5:0] now_second;
   } req_type;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [7:0] target_id;
      logic       is_timed;
      logic       last_of_run;
   } rsp_type;

endpackage

### src/slot_and_round_robin_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot and round-robin scheduler
// Admits timed and round-robin tasks and emits stop/resume events per tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | srrs_pkg::req_type
//  rsp     | out       | rsp_valid/stall   | srrs_pkg::rsp_type
//
// One request is handled at a time. An admit first sorts the timed table with a
// single compare unit, one compare per cycle, when it holds two or more timed
// entries. A timed admit then scans the table one entry per cycle and issues its
// result once the output register is free; a round-robin admit skips the scan.
// A tick checks each timed entry for a stop, then a resume, ends the walk,
// emits the rotation stop and resume, and flushes the last result. Each result
// waits in the output register until it is taken, so a stall on rsp holds the
// walk. Reset clears counts and control state; the tables need no clearing.
module slot_and_round_robin_scheduler #(
   parameter int TIMED_SLOTS    = 16,
   parameter int ROTATION_SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  srrs_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output srrs_pkg::rsp_type   rsp_data
);

   localparam int TW = (TIMED_SLOTS > 1) ? $clog2(TIMED_SLOTS) : 1;
   localparam int RW = (ROTATION_SLOTS > 1) ? $clog2(ROTATION_SLOTS) : 1;
   localparam int TC = $clog2(TIMED_SLOTS + 1);
   localparam int RC = $clog2(ROTATION_SLOTS + 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SORT   = 7'b0000010,
      ST_SWAP   = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_TICK   = 7'b0010000,
      ST_ROT    = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [5:0] slot_start_ff  [TIMED_SLOTS];
   logic [5:0] slot_length_ff [TIMED_SLOTS];
   logic [7:0] slot_task_ff   [TIMED_SLOTS];
   logic [7:0] rot_task_ff    [ROTATION_SLOTS];

   logic [TC-1:0] slot_count_ff, slot_count_in;
   logic [RC-1:0] rot_count_ff, rot_count_in;
   logic [RC-1:0] rot_ptr_ff, rot_ptr_in;
   logic          timed_running_ff, timed_running_in;

   srrs_pkg::req_type req_ff, req_in;
   logic [TC-1:0] i_ff, i_in;
   logic [TC-1:0] j_ff, j_in;
   logic [TC-1:0] m_ff, m_in;
   logic          conflict_ff, conflict_in;
   // Tick walk: phase 0 checks stop, phase 1 checks resume.
   logic          phase_ff, phase_in;
   logic          rot_phase_ff, rot_phase_in;

   logic              rsp_valid_ff, rsp_valid_in;
   srrs_pkg::rsp_type rsp_ff, rsp_in;
   // Pending result held until the next one (or the end) shows whether it is last.
   logic              pend_ff, pend_in;
   srrs_pkg::rsp_type pend_data_ff, pend_data_in;

   // Table write controls
   logic          swap_en;
   logic          slot_wr_en;
   logic          rot_wr_en;

   logic [TW-1:0] ia, ja, ma;
   logic [RW-1:0] rp, rl;
   logic [6:0]    end_sum;
   logic [6:0]    slot_end;
   logic [RW-1:0] rot_last;
   logic [RC-1:0] rot_cur;

   logic          emit_go;
   logic          out_free;

   assign ia = i_ff[TW-1:0];
   assign ja = j_ff[TW-1:0];
   assign ma = m_ff[TW-1:0];
   assign slot_end = {1'b0, slot_start_ff[ia]} + {1'b0, slot_length_ff[ia]};
   assign end_sum  = {1'b0, req_ff.start_second} + {1'b0, req_ff.run_seconds};
   assign rot_cur  = (rot_ptr_ff >= rot_count_ff) ? '0 : rot_ptr_ff;
   assign rot_last = (rot_cur == '0) ? RW'(rot_count_ff - RC'(1)) : RW'(rot_cur - RC'(1));
   assign rp = rot_cur[RW-1:0];
   assign rl = rot_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in         = state_ff;
      slot_count_in    = slot_count_ff;
      rot_count_in     = rot_count_ff;
      rot_ptr_in       = rot_ptr_ff;
      timed_running_in = timed_running_ff;
      req_in           = req_ff;
      i_in             = i_ff;
      j_in             = j_ff;
      m_in             = m_ff;
      conflict_in      = conflict_ff;
      phase_in         = phase_ff;
      rot_phase_in     = rot_phase_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_in           = rsp_ff;
      pend_in          = pend_ff;
      pend_data_in     = pend_data_ff;
      swap_en          = 1'b0;
      slot_wr_en       = 1'b0;
      rot_wr_en        = 1'b0;
      emit_go          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               i_in   = '0;
               j_in   = TC'(1);
               m_in   = '0;
               conflict_in = 1'b0;
               phase_in    = 1'b0;
               rot_phase_in = 1'b0;
               pend_in     = 1'b0;
               if (req_data.opcode == srrs_pkg::OP_TICK) begin
                  state_in = ST_TICK;
               end else if (slot_count_ff < TC'(2)) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_SORT;
               end
            end
         end
         // Selection sort: one compare per cycle, then a swap at each position.
         ST_SORT: begin
            if (j_ff < slot_count_ff) begin
               if (slot_start_ff[ja] < slot_start_ff[ma]) begin
                  m_in = j_ff;
               end
               j_in = j_ff + TC'(1);
            end else begin
               state_in = ST_SWAP;
            end
         end
         ST_SWAP: begin
            swap_en = 1'b1;
            if (i_ff + TC'(2) >= slot_count_ff) begin
               i_in     = '0;
               state_in = ST_CHECK;
            end else begin
               i_in     = i_ff + TC'(1);
               m_in     = i_ff + TC'(1);
               j_in     = i_ff + TC'(2);
               state_in = ST_SORT;
            end
         end
         // Conflict scan over the sorted table, one entry per cycle.
         ST_CHECK: begin
            if (req_ff.timed_policy && end_sum <= 7'(srrs_pkg::WINDOW_SECONDS)
                && i_ff < slot_count_ff) begin
               if (req_ff.task_id > slot_task_ff[ia] && slot_length_ff[ia] != '0
                   && req_ff.start_second >= slot_start_ff[ia]
                   && {1'b0, req_ff.start_second} < slot_end) begin
                  conflict_in = 1'b1;
               end
               i_in = i_ff + TC'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.target_id   = req_ff.task_id;
               rsp_in.is_timed    = req_ff.timed_policy;
               rsp_in.last_of_run = 1'b1;
               state_in = ST_IDLE;
               if (req_ff.timed_policy) begin
                  if (end_sum > 7'(srrs_pkg::WINDOW_SECONDS)) begin
                     rsp_in.event_kind = srrs_pkg::EV_PAST;
                  end else if (conflict_ff) begin
                     rsp_in.event_kind = srrs_pkg::EV_CONFLICT;
                  end else if (slot_count_ff >= TC'(TIMED_SLOTS)) begin
                     rsp_in.event_kind = srrs_pkg::EV_FULL;
                  end else begin
                     rsp_in.event_kind = srrs_pkg::EV_ADMIT;
                     slot_wr_en    = 1'b1;
                     slot_count_in = slot_count_ff + TC'(1);
                  end
               end else if (rot_count_ff >= RC'(ROTATION_SLOTS)) begin
                  rsp_in.event_kind = srrs_pkg::EV_FULL;
               end else begin
                  rsp_in.event_kind = srrs_pkg::EV_ADMIT;
                  rot_wr_en    = 1'b1;
                  rot_count_in = rot_count_ff + RC'(1);
               end
            end
         end
         // Tick walk: each candidate result goes through the pending register.
         ST_TICK: begin
            if (i_ff >= slot_count_ff) begin
               state_in = ST_ROT;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               if ({1'b0, req_ff.now_second} + 7'd1 == slot_end) begin
                  timed_running_in = 1'b0;
                  pend_data_in.event_kind  = srrs_pkg::EV_STOP;
                  pend_data_in.target_id   = slot_task_ff[ia];
                  pend_data_in.is_timed    = 1'b1;
                  pend_data_in.last_of_run = 1'b0;
                  emit_go = 1'b1;
               end
            end else begin
               phase_in = 1'b0;
               i_in     = i_ff + TC'(1);
               if (req_ff.now_second == slot_start_ff[ia]) begin
                  timed_running_in = 1'b1;
                  pend_data_in.event_kind  = srrs_pkg::EV_RESUME;
                  pend_data_in.target_id   = slot_task_ff[ia];
                  pend_data_in.is_timed    = 1'b1;
                  pend_data_in.last_of_run = 1'b0;
                  emit_go = 1'b1;
               end
            end
            if (emit_go) begin
               if (pend_ff && !out_free) begin
                  // Hold this step until the output register frees up.
                  state_in         = state_ff;
                  phase_in         = phase_ff;
                  i_in             = i_ff;
                  timed_running_in = timed_running_ff;
                  pend_data_in     = pend_data_ff;
               end else begin
                  pend_in = 1'b1;
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_data_ff;
                  end
               end
            end
         end
         ST_ROT: begin
            if (timed_running_ff || rot_count_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               if (!rot_phase_ff) begin
                  pend_data_in.event_kind  = srrs_pkg::EV_STOP;
                  pend_data_in.target_id   = rot_task_ff[rl];
                  pend_data_in.is_timed    = 1'b0;
                  pend_data_in.last_of_run = 1'b0;
               end else begin
                  pend_data_in.event_kind  = srrs_pkg::EV_RESUME;
                  pend_data_in.target_id   = rot_task_ff[rp];
                  pend_data_in.is_timed    = 1'b0;
                  pend_data_in.last_of_run = 1'b0;
               end
               if (!pend_ff || out_free) begin
                  pend_in = 1'b1;
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_data_ff;
                  end
                  if (rot_phase_ff) begin
                     rot_ptr_in = rot_cur + RC'(1);
                     state_in   = ST_EMIT;
                  end
                  rot_phase_in = 1'b1;
               end else begin
                  pend_data_in = pend_data_ff;
               end
            end
         end
         ST_EMIT: begin
            if (!pend_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_data_ff;
               rsp_in.last_of_run = 1'b1;
               pend_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         slot_count_ff    <= '0;
         rot_count_ff     <= '0;
         rot_ptr_ff       <= '0;
         timed_running_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         pend_ff          <= 1'b0;
      end else begin
         state_ff         <= state_in;
         slot_count_ff    <= slot_count_in;
         rot_count_ff     <= rot_count_in;
         rot_ptr_ff       <= rot_ptr_in;
         timed_running_ff <= timed_running_in;
         rsp_valid_ff     <= rsp_valid_in;
         pend_ff          <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      m_ff         <= m_in;
      conflict_ff  <= conflict_in;
      phase_ff     <= phase_in;
      rot_phase_ff <= rot_phase_in;
      rsp_ff       <= rsp_in;
      pend_data_ff <= pend_data_in;
      if (swap_en) begin
         slot_start_ff[ia]  <= slot_start_ff[ma];
         slot_start_ff[ma]  <= slot_start_ff[ia];
         slot_length_ff[ia] <= slot_length_ff[ma];
         slot_length_ff[ma] <= slot_length_ff[ia];
         slot_task_ff[ia]   <= slot_task_ff[ma];
         slot_task_ff[ma]   <= slot_task_ff[ia];
      end else if (slot_wr_en) begin
         slot_start_ff[slot_count_ff[TW-1:0]]  <= req_ff.start_second;
         slot_length_ff[slot_count_ff[TW-1:0]] <= req_ff.run_seconds;
         slot_task_ff[slot_count_ff[TW-1:0]]   <= req_ff.task_id;
      end
      if (rot_wr_en) begin
         rot_task_ff[rot_count_ff[RW-1:0]] <= req_ff.task_id;
      end
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler testbench
// Drives admit and tick requests into the slot and round-robin scheduler,
// predicts every stop, resume and admission result, and compares them in order.
// ----------------------------------------------------------------------------
module testbench;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   srrs_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   srrs_pkg::rsp_type rsp_data;

   slot_and_round_robin_scheduler u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted scheduler state.
   logic [5:0] sched_start [16];
   logic [5:0] sched_len [16];
   logic [7:0] sched_task [16];
   int         sched_count;
   logic [7:0] rr_task [16];
   int         rr_count;
   int         rr_ptr;
   bit         timed_on;

   srrs_pkg::req_type pending_q[$];
   srrs_pkg::rsp_type expected_q[$];
   int         mismatches = 0;
   bit         quiet = 1'b0;
   bit         hold_send = 1'b0;
   int         send_gap = 0;
   int         take_gap = 0;

   function automatic srrs_pkg::rsp_type make_rsp(logic [2:0] k, logic [7:0] id, logic t);
      srrs_pkg::rsp_type r;
      r.event_kind = k;
      r.target_id = id;
      r.is_timed = t;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   task automatic order_slots();
      int m;
      logic [5:0] s;
      logic [5:0] l;
      logic [7:0] t;
      for (int i = 0; i + 1 < sched_count; i++) begin
         m = i;
         for (int j = i + 1; j < sched_count; j++)
            if (sched_start[j] < sched_start[m]) m = j;
         s = sched_start[m]; sched_start[m] = sched_start[i]; sched_start[i] = s;
         l = sched_len[m]; sched_len[m] = sched_len[i]; sched_len[i] = l;
         t = sched_task[m]; sched_task[m] = sched_task[i]; sched_task[i] = t;
      end
   endtask

   task automatic predict_schedule(srrs_pkg::req_type q);
      srrs_pkg::rsp_type outs[$];
      logic [2:0] k;
      int s;
      int l;
      int prev;
      if (q.opcode == srrs_pkg::OP_ADMIT) begin
         order_slots();
         if (q.timed_policy) begin
            k = srrs_pkg::EV_ADMIT;
            if (int'(q.start_second) + int'(q.run_seconds) > 60) k = srrs_pkg::EV_PAST;
            else begin
               for (int i = 0; i < sched_count; i++) begin
                  s = sched_start[i];
                  l = sched_len[i];
                  if (k == srrs_pkg::EV_ADMIT && q.task_id > sched_task[i] && l > 0 &&
                      q.start_second >= s && q.start_second <= s + l - 1)
                     k = srrs_pkg::EV_CONFLICT;
               end
               if (k == srrs_pkg::EV_ADMIT && sched_count >= 16) k = srrs_pkg::EV_FULL;
               if (k == srrs_pkg::EV_ADMIT) begin
                  sched_start[sched_count] = q.start_second;
                  sched_len[sched_count] = q.run_seconds;
                  sched_task[sched_count] = q.task_id;
                  sched_count++;
               end
            end
         end else if (rr_count >= 16) k = srrs_pkg::EV_FULL;
         else begin
            rr_task[rr_count] = q.task_id;
            rr_count++;
            k = srrs_pkg::EV_ADMIT;
         end
         outs.push_back(make_rsp(k, q.task_id, q.timed_policy));
      end else begin
         for (int i = 0; i < sched_count; i++) begin
            s = sched_start[i];
            l = sched_len[i];
            if (int'(q.now_second) + 1 == s + l) begin
               timed_on = 1'b0;
               outs.push_back(make_rsp(srrs_pkg::EV_STOP, sched_task[i], 1'b1));
            end
            if (int'(q.now_second) == s) begin
               timed_on = 1'b1;
               outs.push_back(make_rsp(srrs_pkg::EV_RESUME, sched_task[i], 1'b1));
            end
         end
         if (!timed_on && rr_count > 0) begin
            prev = rr_ptr - 1;
            if (rr_ptr >= rr_count) rr_ptr = 0;
            if (rr_ptr == 0) prev = rr_count - 1;
            outs.push_back(make_rsp(srrs_pkg::EV_STOP, rr_task[prev % 16], 1'b0));
            outs.push_back(make_rsp(srrs_pkg::EV_RESUME, rr_task[rr_ptr % 16], 1'b0));
            rr_ptr++;
         end
      end
      if (outs.size() > 0) outs[outs.size() - 1].last_of_run = 1'b1;
      foreach (outs[i]) expected_q.push_back(outs[i]);
   endtask

   function automatic srrs_pkg::req_type admit_req(logic t, logic [7:0] id, logic [5:0] s,
                                                   logic [5:0] l);
      srrs_pkg::req_type q;
      q = '0;
      q.opcode = srrs_pkg::OP_ADMIT;
      q.timed_policy = t;
      q.task_id = id;
      q.start_second = s;
      q.run_seconds = l;
      q.now_second = 6'($urandom);
      return q;
   endfunction

   function automatic srrs_pkg::req_type tick_req(logic [5:0] n);
      srrs_pkg::req_type q;
      q = 28'($urandom);
      q.opcode = srrs_pkg::OP_TICK;
      q.now_second = n;
      return q;
   endfunction

   // Driver: the expectation is formed when the request is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_schedule(req_data);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (hold_send || pending_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(1, 17) - 1;
               req_valid <= 1'b0;
            end else begin
               req_data <= pending_q.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // Monitor and receiver stall.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               if (rsp_data !== expected_q[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", expected_q[0], rsp_data);
               end
               void'(expected_q.pop_front());
            end
         end
         if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            take_gap <= $urandom_range(1, 17) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic wait_drained();
      while (pending_q.size() > 0 || req_valid || expected_q.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int sec;
      int kind;
      logic [7:0] id;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // Directed: empty tick, window edges, conflicts, zero length.
      pending_q.push_back(tick_req(6'd0));
      pending_q.push_back(admit_req(1'b1, 8'd10, 6'd0, 6'd60));
      pending_q.push_back(admit_req(1'b1, 8'd11, 6'd63, 6'd63));
      pending_q.push_back(admit_req(1'b1, 8'd20, 6'd30, 6'd31));
      pending_q.push_back(admit_req(1'b1, 8'd5, 6'd30, 6'd1));
      pending_q.push_back(admit_req(1'b1, 8'd20, 6'd30, 6'd2));
      pending_q.push_back(admit_req(1'b1, 8'd0, 6'd40, 6'd0));
      pending_q.push_back(admit_req(1'b1, 8'd255, 6'd40, 6'd3));
      pending_q.push_back(tick_req(6'd30));
      pending_q.push_back(admit_req(1'b0, 8'd200, 6'd0, 6'd0));
      pending_q.push_back(tick_req(6'd40));
      pending_q.push_back(tick_req(6'd39));
      pending_q.push_back(tick_req(6'd42));
      pending_q.push_back(admit_req(1'b0, 8'd201, 6'd63, 6'd63));
      pending_q.push_back(tick_req(6'd63));
      pending_q.push_back(tick_req(6'd60));
      pending_q.push_back(tick_req(6'd42));
      wait_drained();
      // Every expected result has come; the sender now holds off before the random phase.
      hold_send = 1'b1;
      repeat (20) @(posedge clock);
      hold_send = 1'b0;
      for (int n = 0; n < 410; n++) begin
         kind = $urandom_range(0, 9);
         id = 8'($urandom);
         if (kind < 3) begin
            pending_q.push_back(admit_req(1'b1, id, 6'($urandom_range(0, 59)),
                                          6'($urandom_range(0, 12))));
         end else if (kind == 3) begin
            pending_q.push_back(admit_req(1'b1, id, 6'($urandom), 6'($urandom)));
         end else if (kind == 4) begin
            pending_q.push_back(admit_req(1'b0, id, 6'($urandom), 6'($urandom)));
         end else begin
            sec = (kind == 9) ? $urandom_range(0, 63) : $urandom_range(0, 59);
            pending_q.push_back(tick_req(6'(sec)));
         end
         if (n == 330) begin
            wait_drained();
            quiet = 1'b1;
         end
      end
      wait_drained();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #20000000;
      $display("testbench: done, errors");
      $finish;
   end
endmodule

### filelist.f
src/srrs_pkg.sv
src/slot_and_round_robin_scheduler.sv
tb/sv/testbench.sv
